### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SITDA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sitda_pkg.sv
// Shared constants, types and microcode table for the decimal ASCII converter.
package sitda_pkg;

   // Converted width; must not exceed the width of the value field.
   localparam int DATA_WIDTH  = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;

   // Decimal digits needed for the largest magnitude, 2**(DATA_WIDTH-1).
   function automatic int decimal_digits(int width);
      longint unsigned mag;
      int              n;
      mag = longint'(64'd1 << (width - 1));
      n   = 0;
      do begin
         mag = mag / 10;
         n++;
      end while (mag != 0);
      return n;
   endfunction

   localparam int NUM_DIGITS   = decimal_digits(DATA_WIDTH);
   localparam int BCD_WIDTH    = 4 * NUM_DIGITS;
   localparam int BITCNT_WIDTH = $clog2(DATA_WIDTH + 1);
   localparam int DIGCNT_WIDTH = $clog2(NUM_DIGITS + 1);

   typedef logic [CHAR_WIDTH-1:0] char_type;

   localparam char_type CHAR_MINUS = char_type'(45);
   localparam char_type CHAR_ZERO  = char_type'(48);
   localparam char_type CHAR_NINE  = char_type'(57);

   // Datapath operations, one per microcode step.
   typedef enum logic [5:0] {
      OP_NOP   = 6'b000001,
      OP_LOAD  = 6'b000010,
      OP_SHIFT = 6'b000100,
      OP_SIGN  = 6'b001000,
      OP_TRIM  = 6'b010000,
      OP_EMIT  = 6'b100000
   } op_type;

   // Sequencing: next step, stay while datapath reports more, or jump.
   typedef enum logic [1:0] {
      COND_STEP  = 2'd0,
      COND_UNTIL = 2'd1,
      COND_JUMP  = 2'd2
   } cond_type;

   localparam int PC_WIDTH = 3;
   typedef logic [PC_WIDTH-1:0] pc_type;

   localparam pc_type PC_LOAD  = pc_type'(0);
   localparam pc_type PC_SHIFT = pc_type'(1);
   localparam pc_type PC_SIGN  = pc_type'(2);
   localparam pc_type PC_TRIM  = pc_type'(3);
   localparam pc_type PC_EMIT  = pc_type'(4);

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   // Datapath feedback to the sequencer.
   typedef struct packed {
      logic hold;   // step cannot complete this cycle
      logic more;   // loop condition of the current step
   } status_type;

   function automatic uword_type microcode(pc_type pc);
      uword_type w;
      unique case (pc)
         PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_STEP,  target: PC_SHIFT};
         PC_SHIFT: w = '{op: OP_SHIFT, cond: COND_UNTIL, target: PC_SIGN};
         PC_SIGN:  w = '{op: OP_SIGN,  cond: COND_STEP,  target: PC_TRIM};
         PC_TRIM:  w = '{op: OP_TRIM,  cond: COND_UNTIL, target: PC_EMIT};
         PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_UNTIL, target: PC_LOAD};
         default:  w = '{op: OP_NOP,   cond: COND_JUMP,  target: PC_LOAD};
      endcase
      return w;
   endfunction

endpackage

### hdl/sitda_channels.sv
// Valid/ready channel interfaces for the request and response sides.
interface sitda_req_if
   import sitda_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if
   import sitda_pkg::*;
   ();
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

### hdl/sitda_datapath.sv
// Double-dabble datapath and output register driven by the microcode op.
module sitda_datapath
   import sitda_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  op_type         op,
   output status_type     status,
   sitda_req_if.sink      req_chan,
   sitda_rsp_if.source    rsp_chan
);

   logic [DATA_WIDTH-1:0]   bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic                    neg_ff, neg_in;
   logic [BITCNT_WIDTH-1:0] bitcnt_ff, bitcnt_in;
   logic [DIGCNT_WIDTH-1:0] digcnt_ff, digcnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   char_type                char_ff, char_in;
   logic                    last_ff, last_in;

   logic [DATA_WIDTH-1:0]   value_w;
   logic [DATA_WIDTH-1:0]   mag_w;
   logic [BCD_WIDTH-1:0]    adj_w;
   logic [3:0]              top_w;
   logic                    out_free_w;

   assign value_w    = req_chan.value[DATA_WIDTH-1:0];
   assign mag_w      = value_w[DATA_WIDTH-1] ? (~value_w + DATA_WIDTH'(1)) : value_w;
   assign top_w      = bcd_ff[BCD_WIDTH-1 -: 4];
   assign out_free_w = !rsp_valid_ff || rsp_chan.ready;

   // add-3 correction per digit before each shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj_w[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      bitcnt_in    = bitcnt_ff;
      digcnt_in    = digcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      status       = '{hold: 1'b0, more: 1'b0};

      unique case (op)
         OP_LOAD: begin
            status.hold = !req_chan.valid;
            if (req_chan.valid) begin
               bin_in    = mag_w;
               neg_in    = value_w[DATA_WIDTH-1];
               bcd_in    = '0;
               bitcnt_in = BITCNT_WIDTH'(DATA_WIDTH);
               digcnt_in = DIGCNT_WIDTH'(NUM_DIGITS);
            end
         end
         OP_SHIFT: begin
            bcd_in      = {adj_w[BCD_WIDTH-2:0], bin_ff[DATA_WIDTH-1]};
            bin_in      = {bin_ff[DATA_WIDTH-2:0], 1'b0};
            bitcnt_in   = bitcnt_ff - BITCNT_WIDTH'(1);
            status.more = (bitcnt_ff != BITCNT_WIDTH'(1));
         end
         OP_SIGN: begin
            if (neg_ff) begin
               status.hold = !out_free_w;
               if (out_free_w) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_MINUS;
                  last_in      = 1'b0;
               end
            end
         end
         OP_TRIM: begin
            // drop leading zero digits, keep at least one
            status.more = (top_w == 4'd0) && (digcnt_ff != DIGCNT_WIDTH'(1));
            if (status.more) begin
               bcd_in    = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               digcnt_in = digcnt_ff - DIGCNT_WIDTH'(1);
            end
         end
         OP_EMIT: begin
            status.hold = !out_free_w;
            status.more = (digcnt_ff != DIGCNT_WIDTH'(1));
            if (out_free_w) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_ZERO + char_type'(top_w);
               last_in      = (digcnt_ff == DIGCNT_WIDTH'(1));
               bcd_in       = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               digcnt_in    = digcnt_ff - DIGCNT_WIDTH'(1);
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      neg_ff    <= neg_in;
      bitcnt_ff <= bitcnt_in;
      digcnt_ff <= digcnt_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   // no transfer while reset holds the sequencer
   assign req_chan.ready     = (op == OP_LOAD) && !reset;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

### hdl/signed_int_to_decimal_ascii.sv
// Top level: microcoded sequencer around the signed integer to decimal ASCII datapath.
// Order: after the double-dabble loop, the SIGN step registers '-' for negative values; the TRIM step
//   drops leading zero digits, then the EMIT step registers the digits in order, last on the final one.
// A new request is taken only in the load step, after the last digit of the previous item has been
//   registered; output stalls hold the sign and emit steps.
// Reset (synchronous): step counter returns to the load step, response valid clears.
module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sitda_req_if.sink   req_chan,
   sitda_rsp_if.source rsp_chan
);

   // Program (see microcode() in the package):
   //   LOAD  - wait for a request transfer, latch magnitude and sign
   //   SHIFT - one double-dabble shift per cycle, DATA_WIDTH times
   //   SIGN  - put '-' in the output register for negative values
   //   TRIM  - shift out leading zero digits, one per cycle, keep at least one
   //   EMIT  - one digit per cycle while the output is free, into the output register, last on the final one
   pc_type     pc_ff, pc_in;
   uword_type  uword;
   status_type status;

   assign uword = microcode(pc_ff);

   // Hold stalls the step; COND_UNTIL repeats the step while the datapath says more.
   always_comb begin
      if (status.hold) begin
         pc_in = pc_ff;
      end else begin
         unique case (uword.cond)
            COND_STEP:  pc_in = pc_ff + pc_type'(1);
            COND_UNTIL: pc_in = status.more ? pc_ff : uword.target;
            COND_JUMP:  pc_in = uword.target;
            default:    pc_in = PC_LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Datapath holds the shift registers, counters and the response register,
   // so a finished character waits there while the program moves on.
   sitda_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .op       (uword.op),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### hdl/sitda_checker.sv
// Port-level checker for the converter and its bind to the top level.
`include "assert_macros.svh"

module sitda_checker
   import sitda_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input char_type rsp_character,
   input logic     rsp_last
);

   // items accepted whose last character has not yet transferred
   logic [1:0] pend_ff, pend_in;
   logic       req_xfer;
   logic       last_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign last_xfer = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      pend_in = pend_ff + 2'(req_xfer) - 2'(last_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `SITDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_character) && $stable(rsp_last), "response changed while stalled")
   `SITDA_ASSERT(a_one_in_work, clock, reset, req_xfer |-> (pend_ff <= 2'd1), "request taken with two items open")
   `SITDA_ASSERT(a_no_orphan, clock, reset, rsp_valid |-> (pend_ff != 2'd0), "response without an open item")
   `SITDA_ASSERT(a_char_range, clock, reset, rsp_valid |-> ((rsp_character == CHAR_MINUS) || ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_NINE))), "character outside sign and digits")
   `SITDA_ASSERT(a_sign_not_last, clock, reset, (rsp_valid && (rsp_character == CHAR_MINUS)) |-> !rsp_last, "sign flagged as last")

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_character (rsp_chan.character),
   .rsp_last      (rsp_chan.last)
);
